// ===== rtl/smia_pkg.sv =====
// package for the stack machine integer alu: codes, types and constants
package smia_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ActW = 6;
  localparam int unsigned TrapW = 2;
  localparam int unsigned ShW = 4;
  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [5:0] {
    OP_UCHK = 6'd0, OP_ULSS = 6'd1, OP_ULEQ = 6'd2, OP_UGTR = 6'd3, OP_UGEQ = 6'd4,
    OP_UADD = 6'd5, OP_USUB = 6'd6, OP_UMUL = 6'd7, OP_UDIV = 6'd8, OP_UMOD = 6'd9,
    OP_ROR = 6'd10, OP_SHL = 6'd11, OP_SHR = 6'd12, OP_CHK = 6'd13, OP_CHKZ = 6'd14,
    OP_CHKS = 6'd15, OP_EQL = 6'd16, OP_NEQ = 6'd17, OP_LSS = 6'd18, OP_LEQ = 6'd19,
    OP_GTR = 6'd20, OP_GEQ = 6'd21, OP_ABS = 6'd22, OP_NEG = 6'd23, OP_OR = 6'd24,
    OP_XOR = 6'd25, OP_AND = 6'd26, OP_COM = 6'd27, OP_IN = 6'd28, OP_MSK = 6'd29,
    OP_NOT = 6'd30, OP_IADD = 6'd31, OP_ISUB = 6'd32, OP_IMUL = 6'd33, OP_IDIV = 6'd34,
    OP_MOD = 6'd35, OP_BIT = 6'd36
  } op_e;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0, TRAP_OVF = 2'd1, TRAP_RANGE = 2'd2, TRAP_ZDIV = 2'd3
  } trap_e;

  // unit class chosen by the front end
  typedef enum logic [1:0] {
    CLS_LOGIC = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
  } cls_e;

  // one decoded request as it travels through the queue
  typedef struct packed {
    logic [ActW-1:0]  action;
    cls_e             cls;
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
    logic [WordW-1:0] upper;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    trap_e            trap;
  } res_t;

endpackage

// ===== rtl/smia_front.sv =====
// front end: takes requests, classifies them by unit, writes the queue
module smia_front #(
  parameter int unsigned Depth = smia_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [smia_pkg::ActW-1:0]     action_i,
  input  logic [smia_pkg::WordW-1:0]    left_i,
  input  logic [smia_pkg::WordW-1:0]    right_i,
  input  logic [smia_pkg::WordW-1:0]    upper_i,
  output logic                          q_valid_o,
  input  logic                          q_take_i,
  output smia_pkg::req_t                q_req_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  smia_pkg::req_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  smia_pkg::req_t  req;
  logic            push, pop;

  always_comb begin
    req.action = action_i;
    req.left   = left_i;
    req.right  = right_i;
    req.upper  = upper_i;
    case (smia_pkg::op_e'(action_i))
      smia_pkg::OP_UMUL, smia_pkg::OP_IMUL: req.cls = smia_pkg::CLS_MUL;
      smia_pkg::OP_UDIV, smia_pkg::OP_UMOD,
      smia_pkg::OP_IDIV, smia_pkg::OP_MOD: req.cls = smia_pkg::CLS_DIV;
      default: req.cls = smia_pkg::CLS_LOGIC;
    endcase
  end

  assign in_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_take_i && q_valid_o;
  assign q_req_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== rtl/smia_div.sv =====
// pipelined 16-bit unsigned divider, one quotient bit per stage
module smia_div (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  logic [smia_pkg::WordW-1:0] dividend_i,
  input  logic [smia_pkg::WordW-1:0] divisor_i,
  output logic [smia_pkg::WordW-1:0] quot_o,
  output logic [smia_pkg::WordW-1:0] rem_o
);
  localparam int unsigned W = smia_pkg::WordW;

  logic [W-1:0] rem_q [W+1];
  logic [W-1:0] quo_q [W+1];
  logic [W-1:0] dvs_q [W+1];

  always_comb begin
    rem_q[0] = '0;
    quo_q[0] = dividend_i;
    dvs_q[0] = divisor_i;
  end

  // stage k shifts in one dividend bit and does one trial subtract
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] trial;
    always_comb trial = {rem_q[k], quo_q[k][W-1]} - {1'b0, dvs_q[k]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dvs_q[k+1] <= dvs_q[k];
        if (!trial[W]) begin
          rem_q[k+1] <= trial[W-1:0];
          quo_q[k+1] <= {quo_q[k][W-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= {rem_q[k][W-2:0], quo_q[k][W-1]};
          quo_q[k+1] <= {quo_q[k][W-2:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = quo_q[W];
  assign rem_o  = rem_q[W];
endmodule

// ===== rtl/smia_back.sv =====
// back end: execution pipeline with multiplier and divider, output register
module smia_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_take_o,
  input  smia_pkg::req_t             q_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [smia_pkg::WordW-1:0] result_o,
  output logic [smia_pkg::TrapW-1:0] trap_o
);
  localparam int unsigned W = smia_pkg::WordW;
  localparam int unsigned Lat = W + 2;

  logic adv;
  logic [Lat-1:0] vld_q;
  smia_pkg::req_t rq_q [Lat];
  smia_pkg::res_t res_q [Lat];
  logic [2*W-1:0] prod_q;
  logic a_neg_q [Lat];
  logic b_neg_q [Lat];

  // whole pipe moves together; a bubble or a free output lets it move
  assign adv = !vld_q[Lat-1] || !out_stall_i;
  assign q_take_o = adv;
  assign out_valid_o = vld_q[Lat-1];
  assign result_o = res_q[Lat-1].result;
  assign trap_o = res_q[Lat-1].trap;

  // stage 0: simple ops, multiply operands, divider magnitudes
  smia_pkg::req_t r;
  smia_pkg::res_t s0;
  logic signed [W-1:0] sa, sb, sc;
  logic [W-1:0] mag_a, mag_b, qt, rm;
  logic [smia_pkg::ShW-1:0] sh;
  logic [W:0] sum;
  logic signed [W:0] ssum;
  logic [2*W-1:0] rot;

  always_comb begin
    r = q_req_i;
    sa = r.left;
    sb = r.right;
    sc = r.upper;
    sh = r.right[smia_pkg::ShW-1:0];
    mag_a = sa[W-1] ? -r.left : r.left;
    mag_b = sb[W-1] ? -r.right : r.right;
    sum = '0;
    ssum = '0;
    rot = {r.left, r.left} >> sh;
    s0.result = '0;
    s0.trap = smia_pkg::TRAP_NONE;
    case (smia_pkg::op_e'(r.action))
      smia_pkg::OP_UCHK: begin
        s0.result = r.left;
        if (r.left < r.right || r.left > r.upper) s0.trap = smia_pkg::TRAP_RANGE;
      end
      smia_pkg::OP_ULSS: s0.result = W'(r.left < r.right);
      smia_pkg::OP_ULEQ: s0.result = W'(r.left <= r.right);
      smia_pkg::OP_UGTR: s0.result = W'(r.left > r.right);
      smia_pkg::OP_UGEQ: s0.result = W'(r.left >= r.right);
      smia_pkg::OP_UADD: begin
        sum = {1'b0, r.left} + {1'b0, r.right};
        s0.result = sum[W-1:0];
        if (sum[W]) s0.trap = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_USUB: begin
        s0.result = r.left - r.right;
        if (r.left < r.right) s0.trap = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_ROR: s0.result = rot[W-1:0];
      smia_pkg::OP_SHL: s0.result = r.left << sh;
      smia_pkg::OP_SHR: s0.result = r.left >> sh;
      smia_pkg::OP_CHK: begin
        s0.result = r.left;
        if (sa < sb || sa > sc) s0.trap = smia_pkg::TRAP_RANGE;
      end
      smia_pkg::OP_CHKZ: begin
        s0.result = r.left;
        if (sa[W-1] || sa > sb) s0.trap = smia_pkg::TRAP_RANGE;
      end
      smia_pkg::OP_CHKS: begin
        s0.result = r.left;
        if (sa[W-1]) s0.trap = smia_pkg::TRAP_RANGE;
      end
      smia_pkg::OP_EQL: s0.result = W'(r.left == r.right);
      smia_pkg::OP_NEQ: s0.result = W'(r.left != r.right);
      smia_pkg::OP_LSS: s0.result = W'(sa < sb);
      smia_pkg::OP_LEQ: s0.result = W'(sa <= sb);
      smia_pkg::OP_GTR: s0.result = W'(sa > sb);
      smia_pkg::OP_GEQ: s0.result = W'(sa >= sb);
      smia_pkg::OP_ABS: s0.result = mag_b;
      smia_pkg::OP_NEG: s0.result = -r.right;
      smia_pkg::OP_OR:  s0.result = r.left | r.right;
      smia_pkg::OP_XOR: s0.result = r.left ^ r.right;
      smia_pkg::OP_AND: s0.result = r.left & r.right;
      smia_pkg::OP_COM: s0.result = ~r.right;
      smia_pkg::OP_IN: begin
        if (r.left[W-1:smia_pkg::ShW] == '0) begin
          s0.result = W'(r.right[W-1-r.left[smia_pkg::ShW-1:0]]);
        end
      end
      smia_pkg::OP_MSK: s0.result = ~({W{1'b1}} >> sh);
      smia_pkg::OP_NOT: s0.result = W'(!r.right[0]);
      smia_pkg::OP_IADD: begin
        ssum = {sa[W-1], sa} + {sb[W-1], sb};
        s0.result = ssum[W-1:0];
        if (ssum[W] != ssum[W-1]) s0.trap = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_ISUB: begin
        ssum = {sa[W-1], sa} - {sb[W-1], sb};
        s0.result = ssum[W-1:0];
        if (ssum[W] != ssum[W-1]) s0.trap = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_BIT: s0.result = {1'b1, {(W-1){1'b0}}} >> sh;
      default: s0 = '0;
    endcase
  end

  logic [W-1:0] div_a, div_b;
  assign div_a = (r.action == smia_pkg::ActW'(smia_pkg::OP_UDIV) ||
                  r.action == smia_pkg::ActW'(smia_pkg::OP_UMOD)) ? r.left : mag_a;
  assign div_b = (r.action == smia_pkg::ActW'(smia_pkg::OP_UDIV) ||
                  r.action == smia_pkg::ActW'(smia_pkg::OP_UMOD)) ? r.right : mag_b;

  smia_div u_div (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quot_o     (qt),
    .rem_o      (rm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], q_valid_i};
    end
  end

  // multiply registered once after stage 0
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (rq_q[0].action == smia_pkg::ActW'(smia_pkg::OP_IMUL)) begin
        prod_q <= (2*W)'($signed(rq_q[0].left) * $signed(rq_q[0].right));
      end else begin
        prod_q <= rq_q[0].left * rq_q[0].right;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rq_q[0] <= r;
      res_q[0] <= s0;
      a_neg_q[0] <= sa[W-1];
      b_neg_q[0] <= sb[W-1];
    end
  end

  for (genvar k = 1; k < Lat; k++) begin : g_pipe
    smia_pkg::res_t nr;
    always_comb begin
      nr = res_q[k-1];
      if (k == 2 && rq_q[k-1].cls == smia_pkg::CLS_MUL) begin
        nr.result = prod_q[W-1:0];
        nr.trap = smia_pkg::TRAP_NONE;
        if (rq_q[k-1].action == smia_pkg::ActW'(smia_pkg::OP_IMUL)) begin
          if (prod_q[2*W-1:W-1] != '0 && prod_q[2*W-1:W-1] != '1)
            nr.trap = smia_pkg::TRAP_OVF;
        end else if (prod_q[2*W-1:W] != '0) begin
          nr.trap = smia_pkg::TRAP_OVF;
        end
      end
      // divider output lines up with stage W-1
      if (k == W && rq_q[k-1].cls == smia_pkg::CLS_DIV) begin
        nr.trap = smia_pkg::TRAP_NONE;
        case (smia_pkg::op_e'(rq_q[k-1].action))
          smia_pkg::OP_UDIV: nr.result = qt;
          smia_pkg::OP_UMOD: nr.result = rm;
          smia_pkg::OP_IDIV: begin
            nr.result = (a_neg_q[k-1] ^ b_neg_q[k-1]) ? -qt : qt;
            // only the most negative over minus one leaves the range
            if (!(a_neg_q[k-1] ^ b_neg_q[k-1]) && qt[W-1]) nr.trap = smia_pkg::TRAP_OVF;
          end
          default: nr.result = a_neg_q[k-1] ? -rm : rm;
        endcase
        if (rq_q[k-1].right == '0) begin
          nr.result = '0;
          nr.trap = smia_pkg::TRAP_ZDIV;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rq_q[k] <= rq_q[k-1];
        a_neg_q[k] <= a_neg_q[k-1];
        b_neg_q[k] <= b_neg_q[k-1];
        res_q[k] <= nr;
      end
    end
  end
endmodule

// ===== rtl/stack_machine_integer_alu.sv =====
// top level of the stack machine 16-bit integer alu
// One request per cycle is taken and one result per cycle is delivered once the
// pipe is full and while the output does not stall. Every request, whatever its
// operation, passes through the queue and then the 18-stage back end, whose depth
// is set by the 16-stage divider, one quotient bit per stage, plus the operand
// stage and the output register. A two-entry queue sits between the front end,
// which accepts and classifies requests, and the back end, so input stays open
// for a while when the output stalls. The whole back-end pipe halts while a
// finished result is held under stall. Unsigned and signed divide/modulo by zero
// give result 0 and trap 3; overflow traps keep the low 16 bits of the true
// result.
module stack_machine_integer_alu #(
  parameter int unsigned QueueDepth = smia_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [smia_pkg::ActW-1:0]   action_i,
  input  logic [smia_pkg::WordW-1:0]  left_i,
  input  logic [smia_pkg::WordW-1:0]  right_i,
  input  logic [smia_pkg::WordW-1:0]  upper_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [smia_pkg::WordW-1:0]  result_o,
  output logic [smia_pkg::TrapW-1:0]  trap_o
);
  logic           q_valid, q_take;
  smia_pkg::req_t q_req;

  // front end and request queue
  smia_front #(.Depth(QueueDepth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .left_i     (left_i),
    .right_i    (right_i),
    .upper_i    (upper_i),
    .q_valid_o  (q_valid),
    .q_take_i   (q_take),
    .q_req_o    (q_req)
  );

  // execution pipe with output register
  smia_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_take_o    (q_take),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .trap_o      (trap_o)
  );

`ifndef SYNTHESIS
  // a held result stays put under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o) && $stable(trap_o))
    else $error("result changed under stall");

  // a divide-by-zero trap always carries a zero word
  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trap_o == smia_pkg::TRAP_ZDIV |-> result_o == '0)
    else $error("divide by zero with nonzero result");

  // a request accepted while the back end is not taking is still in the queue
  a_take_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !q_take |=> q_valid)
    else $error("accepted request lost");
`endif
endmodule

// ===== verif/stack_machine_integer_alu_test.sv =====
// self-checking testbench for the stack machine 16-bit integer alu
module stack_machine_integer_alu_test;

  // one request as presented to the alu
  typedef struct {
    logic [smia_pkg::ActW-1:0]  action;
    logic [smia_pkg::WordW-1:0] left;
    logic [smia_pkg::WordW-1:0] right;
    logic [smia_pkg::WordW-1:0] upper;
  } alu_req_t;

  // the word and trap code that the alu should push back
  typedef struct {
    logic [smia_pkg::WordW-1:0] result;
    smia_pkg::trap_e            trap;
  } alu_outcome_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [smia_pkg::ActW-1:0]  action = '0;
  logic [smia_pkg::WordW-1:0] left = '0;
  logic [smia_pkg::WordW-1:0] right = '0;
  logic [smia_pkg::WordW-1:0] upper = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [smia_pkg::WordW-1:0] result;
  logic [smia_pkg::TrapW-1:0] trap;

  alu_req_t     pending_reqs[$];   // requests not yet presented
  alu_outcome_t outcome_q[$];      // outcomes of accepted requests, oldest first
  alu_req_t     cur_req;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           n_accepted = 0;
  int           n_checked = 0;
  int           n_trapped = 0;
  int           n_errors = 0;

  stack_machine_integer_alu u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .left_i      (left),
    .right_i     (right),
    .upper_i     (upper),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .result_o    (result),
    .trap_o      (trap)
  );

  always #10 clk_i = ~clk_i;

  // bit-exact outcome of one request
  function automatic alu_outcome_t alu_outcome(alu_req_t req);
    logic [31:0]     a, b, r;
    logic [3:0]      sh;
    int              sa, sb, sc, z;
    smia_pkg::trap_e t;
    alu_outcome_t    o;
    a  = {16'h0, req.left};
    b  = {16'h0, req.right};
    sa = $signed({{16{req.left[15]}}, req.left});
    sb = $signed({{16{req.right[15]}}, req.right});
    sc = $signed({{16{req.upper[15]}}, req.upper});
    sh = req.right[3:0];
    r  = '0;
    t  = smia_pkg::TRAP_NONE;
    case (req.action)
      smia_pkg::OP_UCHK: begin
        r = a;
        if (a < b || req.left > req.upper) t = smia_pkg::TRAP_RANGE;
      end
      smia_pkg::OP_ULSS: r = (a < b);
      smia_pkg::OP_ULEQ: r = (a <= b);
      smia_pkg::OP_UGTR: r = (a > b);
      smia_pkg::OP_UGEQ: r = (a >= b);
      smia_pkg::OP_UADD: begin r = a + b; if (r > 32'hffff) t = smia_pkg::TRAP_OVF; end
      smia_pkg::OP_USUB: begin r = a - b; if (a < b) t = smia_pkg::TRAP_OVF; end
      smia_pkg::OP_UMUL: begin r = a * b; if (r > 32'hffff) t = smia_pkg::TRAP_OVF; end
      smia_pkg::OP_UDIV: if (b == 0) t = smia_pkg::TRAP_ZDIV; else r = a / b;
      smia_pkg::OP_UMOD: if (b == 0) t = smia_pkg::TRAP_ZDIV; else r = a % b;
      smia_pkg::OP_ROR:  r = (a >> sh) | (a << ((16 - sh) & 15));
      smia_pkg::OP_SHL:  r = a << sh;
      smia_pkg::OP_SHR:  r = a >> sh;
      smia_pkg::OP_CHK:  begin r = a; if (sa < sb || sa > sc) t = smia_pkg::TRAP_RANGE; end
      smia_pkg::OP_CHKZ: begin r = a; if (sa < 0 || sa > sb) t = smia_pkg::TRAP_RANGE; end
      smia_pkg::OP_CHKS: begin r = a; if (sa < 0) t = smia_pkg::TRAP_RANGE; end
      smia_pkg::OP_EQL:  r = (a == b);
      smia_pkg::OP_NEQ:  r = (a != b);
      smia_pkg::OP_LSS:  r = (sa < sb);
      smia_pkg::OP_LEQ:  r = (sa <= sb);
      smia_pkg::OP_GTR:  r = (sa > sb);
      smia_pkg::OP_GEQ:  r = (sa >= sb);
      smia_pkg::OP_ABS:  r = (sb < 0) ? -sb : sb;
      smia_pkg::OP_NEG:  r = -sb;
      smia_pkg::OP_OR:   r = a | b;
      smia_pkg::OP_XOR:  r = a ^ b;
      smia_pkg::OP_AND:  r = a & b;
      smia_pkg::OP_COM:  r = ~b;
      smia_pkg::OP_IN:   r = (a > 15) ? 0 : (((32'h8000 >> a) & b) != 0);
      smia_pkg::OP_MSK:  r = (sh == 0) ? 0 : (32'hffff << (16 - sh));
      smia_pkg::OP_NOT:  r = b[0] ? 0 : 1;
      smia_pkg::OP_IADD: begin
        z = sa + sb; r = z;
        if (z < -32768 || z > 32767) t = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_ISUB: begin
        z = sa - sb; r = z;
        if (z < -32768 || z > 32767) t = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_IMUL: begin
        z = sa * sb; r = z;
        if (z < -32768 || z > 32767) t = smia_pkg::TRAP_OVF;
      end
      smia_pkg::OP_IDIV: begin
        if (sb == 0) t = smia_pkg::TRAP_ZDIV;
        else begin
          z = sa / sb; r = z;
          if (z < -32768 || z > 32767) t = smia_pkg::TRAP_OVF;
        end
      end
      smia_pkg::OP_MOD:  if (sb == 0) t = smia_pkg::TRAP_ZDIV; else r = sa % sb;
      smia_pkg::OP_BIT:  r = 32'h8000 >> sh;
      default: r = '0;
    endcase
    o.result = r[15:0];
    o.trap   = t;
    return o;
  endfunction

  // operand biased towards the edges of both the signed and unsigned ranges
  function automatic logic [smia_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return 16'($urandom_range(0, 20));
      5: return 16'hffff - 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_req(logic [smia_pkg::ActW-1:0] act, logic [smia_pkg::WordW-1:0] l,
                           logic [smia_pkg::WordW-1:0] r, logic [smia_pkg::WordW-1:0] u);
    alu_req_t req;
    req.action = act;
    req.left   = l;
    req.right  = r;
    req.upper  = u;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_random(int count);
    logic [smia_pkg::ActW-1:0] act;
    repeat (count) begin
      // undefined codes now and then, otherwise any real operation
      if ($urandom_range(0, 19) == 0) act = smia_pkg::ActW'($urandom_range(37, 63));
      else act = smia_pkg::ActW'($urandom_range(0, 36));
      queue_req(act, pick_word(), pick_word(), pick_word());
    end
  endtask

  task automatic drain_pending();
    while (pending_reqs.size() != 0 || in_valid) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  // driver: presents the next request once the previous one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(alu_outcome(cur_req));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          action   <= cur_req.action;
          left     <= cur_req.left;
          right    <= cur_req.right;
          upper    <= cur_req.upper;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each delivered result against the oldest outcome
  always @(posedge clk_i or negedge rst_ni) begin
    alu_outcome_t exp_o;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result %h trap %0d", $time, result, trap);
          n_errors++;
        end else begin
          exp_o = outcome_q.pop_front();
          n_checked++;
          if (exp_o.trap != smia_pkg::TRAP_NONE) n_trapped++;
          if (result !== exp_o.result) begin
            $display("%0t: result mismatch, expected %h actual %h",
                     $time, exp_o.result, result);
            n_errors++;
          end
          if (trap !== exp_o.trap) begin
            $display("%0t: trap mismatch, expected %0d actual %0d",
                     $time, exp_o.trap, trap);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // stimulus and end of run
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners, no idling
    queue_req(smia_pkg::OP_UADD, 16'hffff, 16'h0001, 16'h0);   // unsigned carry out
    queue_req(smia_pkg::OP_USUB, 16'h0000, 16'h0001, 16'h0);   // unsigned borrow
    queue_req(smia_pkg::OP_UMUL, 16'hffff, 16'hffff, 16'h0);
    queue_req(smia_pkg::OP_UDIV, 16'h1234, 16'h0000, 16'h0);   // divide by zero
    queue_req(smia_pkg::OP_UMOD, 16'hffff, 16'h0000, 16'h0);
    queue_req(smia_pkg::OP_IDIV, 16'h8000, 16'hffff, 16'h0);   // most negative over minus one
    queue_req(smia_pkg::OP_IDIV, 16'h8000, 16'h0000, 16'h0);
    queue_req(smia_pkg::OP_IDIV, 16'hfff9, 16'h0002, 16'h0);   // truncation towards zero
    queue_req(smia_pkg::OP_MOD,  16'h8000, 16'hffff, 16'h0);
    queue_req(smia_pkg::OP_MOD,  16'hfff9, 16'h0002, 16'h0);   // remainder follows dividend
    queue_req(smia_pkg::OP_MOD,  16'h0007, 16'h0000, 16'h0);
    queue_req(smia_pkg::OP_IADD, 16'h7fff, 16'h0001, 16'h0);   // positive overflow
    queue_req(smia_pkg::OP_IADD, 16'h8000, 16'hffff, 16'h0);   // negative overflow
    queue_req(smia_pkg::OP_ISUB, 16'h8000, 16'h0001, 16'h0);
    queue_req(smia_pkg::OP_ISUB, 16'h7fff, 16'hffff, 16'h0);
    queue_req(smia_pkg::OP_IMUL, 16'h8000, 16'hffff, 16'h0);
    queue_req(smia_pkg::OP_ABS,  16'h0000, 16'h8000, 16'h0);
    queue_req(smia_pkg::OP_NEG,  16'h0000, 16'h8000, 16'h0);
    queue_req(smia_pkg::OP_IN,   16'h0010, 16'hffff, 16'h0);   // bit index beyond the word
    queue_req(smia_pkg::OP_IN,   16'h0000, 16'h8000, 16'h0);
    queue_req(smia_pkg::OP_MSK,  16'h0000, 16'h0010, 16'h0);   // zero count gives no ones
    queue_req(smia_pkg::OP_MSK,  16'h0000, 16'h000f, 16'h0);
    queue_req(smia_pkg::OP_ROR,  16'h8001, 16'hfff1, 16'h0);
    queue_req(smia_pkg::OP_CHK,  16'h8000, 16'h8000, 16'h7fff);
    queue_req(smia_pkg::OP_UCHK, 16'hffff, 16'h0000, 16'hfffe);
    queue_req(6'h3f,             16'hffff, 16'hffff, 16'hffff); // undefined code
    drain_pending();

    queue_random(100);
    drain_pending();
    send_idle_pct = 80;
    queue_random(100);
    drain_pending();
    send_idle_pct = 0;
    recv_stall_pct = 80;
    queue_random(100);
    drain_pending();
    send_idle_pct = 38;
    recv_stall_pct = 38;
    queue_random(100);
    drain_pending();
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    // room for any stray result from the 18-deep pipe
    repeat (40) @(posedge clk_i);

    $display("%0d requests accepted, %0d results checked, %0d with a trap",
             n_accepted, n_checked, n_trapped);
    $display("idling phases: none, sender, receiver, both");
    if (n_errors == 0) begin
      $display("stack_machine_integer_alu_test passed");
    end else begin
      $display("stack_machine_integer_alu_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("stack_machine_integer_alu_test failed");
    $finish;
  end

endmodule
